>>> hdl/welf_pkg.sv
// Shared types and constants of the windowed running speed statistics block.
package welf_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned SAMPLE_W       = 24;
  localparam int unsigned MEAN_W         = 32;
  localparam int unsigned M2_W           = 64;
  localparam int unsigned WINDOW_W       = 16;
  // Width of the shared compare and subtract of the divide and root steps.
  localparam int unsigned SUB_W          = 36;
  localparam int unsigned STEP_W         = 7;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd300;
  localparam logic [STEP_W-1:0]   STEPS_DIV_MEAN = 7'd33;
  localparam logic [STEP_W-1:0]   STEPS_DIV_VAR  = 7'd64;
  localparam logic [STEP_W-1:0]   STEPS_SQRT     = 7'd32;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  typedef enum logic [1:0] {
    OP_DIV_MEAN = 2'd0,
    OP_DIV_VAR  = 2'd1,
    OP_SQRT     = 2'd2
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_ctl_t;

endpackage

>>> hdl/welf_divsqrt.sv
// Shared iterative unit: restoring divide and bit-pair square root, one bit a cycle.
module welf_divsqrt #(
  parameter int unsigned COUNT_BITS = welf_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  welf_pkg::unit_ctl_t    ctl_i,
  input  logic [63:0]            operand_i,
  input  logic [COUNT_BITS-1:0]  divisor_i,
  output logic [63:0]            result_o,
  output logic                   done_o
);

  localparam int unsigned SubW = welf_pkg::SUB_W;

  welf_pkg::unit_op_e op_q;
  logic [welf_pkg::STEP_W-1:0] cnt_q;
  logic [welf_pkg::STEP_W-1:0] steps;
  logic                        done_q;
  logic [SubW-1:0]             acc_q, acc_d;
  logic [63:0]                 q_q, q_d;
  logic [31:0]                 root_q, root_d;
  logic [SubW-1:0]             cand, trial;
  logic [SubW:0]               diff;
  logic                        fits;
  logic                        is_sqrt;

  always_comb begin
    unique case (ctl_i.op)
      welf_pkg::OP_DIV_MEAN: steps = welf_pkg::STEPS_DIV_MEAN;
      welf_pkg::OP_DIV_VAR:  steps = welf_pkg::STEPS_DIV_VAR;
      welf_pkg::OP_SQRT:     steps = welf_pkg::STEPS_SQRT;
      default:               steps = welf_pkg::STEPS_DIV_VAR;
    endcase
  end

  assign is_sqrt = (op_q == welf_pkg::OP_SQRT);

  // One compare and subtract serves both operations.
  always_comb begin
    if (is_sqrt) begin
      cand  = {acc_q[SubW-3:0], q_q[63:62]};
      trial = {2'b00, root_q, 2'b01};
    end else begin
      cand  = SubW'({acc_q[COUNT_BITS-1:0], q_q[63]});
      trial = SubW'(divisor_i);
    end
    diff  = {1'b0, cand} - {1'b0, trial};
    fits  = ~diff[SubW];
    acc_d = fits ? diff[SubW-1:0] : cand;
    if (is_sqrt) begin
      q_d    = {q_q[61:0], 2'b00};
      root_d = {root_q[30:0], fits};
    end else begin
      q_d    = {q_q[62:0], fits};
      root_d = root_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      op_q   <= welf_pkg::OP_DIV_MEAN;
    end else begin
      done_q <= (cnt_q == welf_pkg::STEP_W'(1));
      if (ctl_i.start) begin
        cnt_q <= steps;
        op_q  <= ctl_i.op;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - welf_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      acc_q  <= '0;
      root_q <= '0;
      if (ctl_i.op == welf_pkg::OP_DIV_MEAN) begin
        q_q <= {operand_i[32:0], 31'b0};
      end else begin
        q_q <= operand_i;
      end
    end else if (cnt_q != '0) begin
      acc_q  <= acc_d;
      q_q    <= q_d;
      root_q <= root_d;
    end
  end

  assign result_o = is_sqrt ? 64'(root_q) : q_q;
  assign done_o   = done_q;

endmodule

>>> hdl/welf_mul.sv
// Product of two 33-bit magnitudes from four 17x17 partial products, taken one after another.
module welf_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] a_i,
  input  logic [32:0] b_i,
  output logic [64:0] prod_o,
  output logic        done_o
);

  logic [32:0] a_q, b_q;
  logic [1:0]  ph_q, sh_q;
  logic        run_q, pv_q, done_q;
  logic [16:0] ma, mb;
  logic [33:0] p_q;
  logic [64:0] acc_q, p_shift;

  // Phase bit 1 picks the upper half of a, bit 0 the upper half of b.
  assign ma = ph_q[1] ? {1'b0, a_q[32:17]} : a_q[16:0];
  assign mb = ph_q[0] ? {1'b0, b_q[32:17]} : b_q[16:0];

  always_comb begin
    case (sh_q)
      2'd0:    p_shift = 65'(p_q);
      2'd3:    p_shift = 65'(p_q) << 34;
      default: p_shift = 65'(p_q) << 17;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= '0;
      sh_q   <= '0;
    end else begin
      done_q <= pv_q && (sh_q == 2'd3);
      pv_q   <= run_q;
      if (start_i) begin
        run_q <= 1'b1;
        ph_q  <= '0;
      end else if (run_q) begin
        sh_q <= ph_q;
        ph_q <= ph_q + 2'd1;
        if (ph_q == 2'd3) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else begin
      if (run_q) begin
        p_q <= ma * mb;
      end
      if (pv_q) begin
        acc_q <= acc_q + p_shift;
      end
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

>>> hdl/running_mean_stddev_min_max_top.sv
// Top level of the windowed running mean, standard deviation, minimum and maximum block.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------
//   in      | input     | in_valid_i/in_ready_o  | mode_i, sample_rpm_i
//   out     | output    | out_valid_o/out_ready_i| sample_count_o .. span_rpm_o
//   cfg     | input     | cfg_we_i, no wait      | cfg_wdata_i (window length)
//
// An add beat passes from acceptance until in_ready_o rises again through the first
// difference, the shared divide unit for the mean step (33 steps, then the quotient is
// taken), the second difference and the partial product multiplier.
// A beat that closes a window then runs the 64-step divide of the squared deviation
// sum and the 32-step square root, each begun from its own start state, and loads the
// output register. An abort beat clears the window and leaves the input open.
// A stalled output holds the block only at a window end.
// Reset is asynchronous and leaves an empty window and a window length of 300 samples.
module running_mean_stddev_min_max_top #(
  parameter int unsigned COUNT_BITS = welf_pkg::COUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic signed [23:0] sample_rpm_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        sample_count_o,
  output logic signed [23:0] mean_rpm_o,
  output logic [22:0]        stddev_rpm_o,
  output logic signed [23:0] min_rpm_o,
  output logic signed [23:0] max_rpm_o,
  output logic signed [24:0] span_rpm_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);

  localparam int unsigned ExtW = COUNT_BITS + welf_pkg::WINDOW_W;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_DIFF1 = 10'b0000000010,
    ST_DIV   = 10'b0000000100,
    ST_DIFF2 = 10'b0000001000,
    ST_MUL   = 10'b0000010000,
    ST_VAR   = 10'b0000100000,
    ST_VDIV  = 10'b0001000000,
    ST_ROOT  = 10'b0010000000,
    ST_SQRT  = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [15:0]               window_q;
  logic [COUNT_BITS-1:0]     count_q;
  logic signed [31:0]        mean_q;
  logic [63:0]               m2_q;
  logic signed [23:0]        min_q, max_q, x_q;
  logic [32:0]               d1_mag_q;
  logic                      d1_neg_q;
  logic                      out_valid_q;

  logic                      in_acc, add_acc, clear_win, out_load;
  logic signed [32:0]        d_cur;
  logic [32:0]               d_mag;
  logic [33:0]               step_ext, mean_sum;
  logic [64:0]               m2_sum;
  logic [63:0]               m2_next;
  logic [15:0]               window_eff;
  logic [ExtW-1:0]           count_ext;
  logic                      window_end;
  logic [32:0]               round_sum;
  logic [22:0]               sd_sat;

  welf_pkg::unit_ctl_t       unit_ctl;
  logic [63:0]               unit_operand, unit_res;
  logic                      unit_done;
  logic                      mul_start, mul_done;
  logic [64:0]               prod;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign add_acc    = in_acc && !mode_i;
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign clear_win  = (in_acc && mode_i) || out_load;

  // The same difference serves d1 (old mean) and d2 (updated mean).
  assign d_cur = $signed({x_q[23], x_q, 8'b0}) - $signed({mean_q[31], mean_q});
  assign d_mag = d_cur[32] ? 33'(-d_cur) : 33'(d_cur);

  assign step_ext = {1'b0, unit_res[32:0]};
  assign mean_sum = {{2{mean_q[31]}}, mean_q} + (d1_neg_q ? 34'(-step_ext) : step_ext);

  assign m2_sum  = {1'b0, m2_q} + 65'(prod[64:16]);
  assign m2_next = m2_sum[64] ? '1 : m2_sum[63:0];

  // A zero window register acts as a window of one sample.
  assign window_eff = (window_q == '0) ? 16'd1 : window_q;
  assign count_ext  = ExtW'(count_q);
  assign window_end = (count_ext >= ExtW'(window_eff)) || (count_q == '1);

  assign round_sum = {mean_q[31], mean_q} + 33'd128;
  assign sd_sat    = (unit_res[31:23] != '0) ? 23'h7FFFFF : unit_res[22:0];

  always_comb begin
    unit_ctl.start = 1'b0;
    unit_ctl.op    = welf_pkg::OP_DIV_MEAN;
    unit_operand   = 64'(d_mag);
    unique case (state_q)
      ST_DIFF1: unit_ctl.start = 1'b1;
      ST_VAR: begin
        unit_ctl.start = 1'b1;
        unit_ctl.op    = welf_pkg::OP_DIV_VAR;
        unit_operand   = (count_q > COUNT_BITS'(1)) ? m2_q : '0;
      end
      ST_ROOT: begin
        unit_ctl.start = 1'b1;
        unit_ctl.op    = welf_pkg::OP_SQRT;
        unit_operand   = unit_res;
      end
      default: ;
    endcase
  end

  assign mul_start = (state_q == ST_DIFF2);

  welf_divsqrt #(
    .COUNT_BITS(COUNT_BITS)
  ) u_divsqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (unit_ctl),
    .operand_i (unit_operand),
    .divisor_i (count_q),
    .result_o  (unit_res),
    .done_o    (unit_done)
  );

  welf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (d1_mag_q),
    .b_i     (d_mag),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (add_acc) state_d = ST_DIFF1;
      ST_DIFF1: state_d = ST_DIV;
      ST_DIV:   if (unit_done) state_d = ST_DIFF2;
      ST_DIFF2: state_d = ST_MUL;
      ST_MUL:   if (mul_done) state_d = window_end ? ST_VAR : ST_IDLE;
      ST_VAR:   state_d = ST_VDIV;
      ST_VDIV:  if (unit_done) state_d = ST_ROOT;
      ST_ROOT:  state_d = ST_SQRT;
      ST_SQRT:  if (unit_done) state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      window_q    <= welf_pkg::WINDOW_RESET;
      count_q     <= '0;
      mean_q      <= '0;
      m2_q        <= '0;
      min_q       <= welf_pkg::SAMPLE_MAX;
      max_q       <= welf_pkg::SAMPLE_MIN;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (clear_win) begin
        count_q <= '0;
        mean_q  <= '0;
        m2_q    <= '0;
        min_q   <= welf_pkg::SAMPLE_MAX;
        max_q   <= welf_pkg::SAMPLE_MIN;
      end else begin
        if (add_acc) begin
          count_q <= count_q + COUNT_BITS'(1);
          if (sample_rpm_i < min_q) min_q <= sample_rpm_i;
          if (sample_rpm_i > max_q) max_q <= sample_rpm_i;
        end
        if ((state_q == ST_DIV) && unit_done) begin
          mean_q <= mean_sum[31:0];
        end
        if ((state_q == ST_MUL) && mul_done) begin
          m2_q <= m2_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_acc) begin
      x_q <= sample_rpm_i;
    end
    if (state_q == ST_DIFF1) begin
      d1_mag_q <= d_mag;
      d1_neg_q <= d_cur[32];
    end
    if (out_load) begin
      sample_count_o <= count_ext[15:0];
      mean_rpm_o     <= round_sum[31:8];
      stddev_rpm_o   <= sd_sat;
      min_rpm_o      <= min_q;
      max_rpm_o      <= max_q;
      span_rpm_o     <= {max_q[23], max_q} - {min_q[23], min_q};
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/welf_checker.sv
// Port-level checks of the running statistics block, bound to its top level.
module welf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               mode_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [15:0]        sample_count_o,
  input logic signed [23:0] mean_rpm_o,
  input logic signed [23:0] min_rpm_o,
  input logic signed [23:0] max_rpm_o,
  input logic signed [24:0] span_rpm_o
);

  // An add beat starts the multi-cycle update, so the input closes right after it.
  a_busy_after_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !mode_i) |=> !in_ready_o)
    else $error("input still open after an add beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(mean_rpm_o)))
    else $error("stalled result beat changed");

  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (span_rpm_o == ({max_rpm_o[23], max_rpm_o} - {min_rpm_o[23], min_rpm_o})))
    else $error("span does not match maximum minus minimum");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((min_rpm_o <= max_rpm_o) && (sample_count_o != 16'd0)))
    else $error("result beat from an empty window");

endmodule

bind running_mean_stddev_min_max_top welf_checker u_welf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .mode_i         (mode_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sample_count_o (sample_count_o),
  .mean_rpm_o     (mean_rpm_o),
  .min_rpm_o      (min_rpm_o),
  .max_rpm_o      (max_rpm_o),
  .span_rpm_o     (span_rpm_o)
);

>>> dv/running_mean_stddev_min_max_top_tb.sv
// Self-checking testbench of the windowed running speed statistics block.
module running_mean_stddev_min_max_top_tb;

  localparam int CLK_HALF      = 6;
  localparam int CLK_PERIOD    = 2 * CLK_HALF;
  localparam int RESET_CYCLES  = 12;
  localparam int MEAN_EXTRA    = 8;
  localparam int COUNT_LIMIT   = 65535;
  localparam int RANDOM_BEATS  = 850;
  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD     = 600;
  localparam int HOLD_PHASE    = 3;
  localparam int REPORT_CAP    = 50;
  localparam longint LIMIT_CYCLES = 1_000_000;
  localparam logic [22:0] STDDEV_SAT = 23'h7FFFFF;

  typedef enum logic {
    BEAT_ADD   = 1'b0,
    BEAT_ABORT = 1'b1
  } beat_kind_e;

  typedef struct {
    beat_kind_e                          kind;
    logic signed [welf_pkg::SAMPLE_W-1:0] speed;
  } speed_beat_t;

  typedef struct {
    logic [15:0]        count;
    logic signed [23:0] mean;
    logic [22:0]        sd;
    logic signed [23:0] lo;
    logic signed [23:0] hi;
    logic signed [24:0] span;
  } window_stats_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic               mode_i       = 1'b0;
  logic signed [23:0] sample_rpm_i = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [15:0]        sample_count_o;
  logic signed [23:0] mean_rpm_o;
  logic [22:0]        stddev_rpm_o;
  logic signed [23:0] min_rpm_o;
  logic signed [23:0] max_rpm_o;
  logic signed [24:0] span_rpm_o;
  logic               cfg_we_i     = 1'b0;
  logic [15:0]        cfg_wdata_i  = '0;

  running_mean_stddev_min_max_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .sample_rpm_i   (sample_rpm_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_count_o (sample_count_o),
    .mean_rpm_o     (mean_rpm_o),
    .stddev_rpm_o   (stddev_rpm_o),
    .min_rpm_o      (min_rpm_o),
    .max_rpm_o      (max_rpm_o),
    .span_rpm_o     (span_rpm_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Predictor state, a mirror of the block's window.
  logic [welf_pkg::WINDOW_W-1:0]        window_len = welf_pkg::WINDOW_RESET;
  int unsigned                          win_count;
  longint                               mean_acc;
  bit [63:0]                            dev_sq_sum;
  logic signed [welf_pkg::SAMPLE_W-1:0] win_lo;
  logic signed [welf_pkg::SAMPLE_W-1:0] win_hi;

  speed_beat_t   pending_beats[$];
  window_stats_t expected_stats[$];

  bit in_fire;
  bit out_fire;
  bit hold_armed;
  bit hold_taken;
  int tx_gap, tx_quiet, rx_stall, rx_quiet;
  int mismatches, beats_accepted, aborts_accepted, results_checked, window_writes;

  function automatic void clear_window_state();
    win_count  = 0;
    mean_acc   = 0;
    dev_sq_sum = '0;
    win_lo     = welf_pkg::SAMPLE_MAX;
    win_hi     = welf_pkg::SAMPLE_MIN;
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] root;
    bit [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Welford update of one accepted add beat; an abort clears the window, a closed window queues its statistics.
  function automatic void predict_beat(beat_kind_e kind,
                                       logic signed [welf_pkg::SAMPLE_W-1:0] speed);
    longint        x, d1, d2, step_sz;
    bit [63:0]     mag1, mag2, term, variance, sd;
    int unsigned   win;
    window_stats_t res;
    if (kind == BEAT_ABORT) begin
      clear_window_state();
      return;
    end
    x = longint'(speed) * (longint'(1) << MEAN_EXTRA);
    win_count++;
    d1 = x - mean_acc;
    mag1 = (d1 < 0) ? -d1 : d1;
    step_sz = longint'(mag1 / win_count);
    mean_acc += (d1 < 0) ? -step_sz : step_sz;
    d2 = x - mean_acc;
    mag2 = (d2 < 0) ? -d2 : d2;
    term = (mag1 * mag2) >> (2 * MEAN_EXTRA);
    dev_sq_sum = (dev_sq_sum > ~term) ? '1 : dev_sq_sum + term;
    if (speed < win_lo) win_lo = speed;
    if (speed > win_hi) win_hi = speed;

    win = (window_len == 0) ? 1 : window_len;
    if (win_count < win && win_count < COUNT_LIMIT) return;

    variance = (win_count > 1) ? dev_sq_sum / win_count : '0;
    sd = int_sqrt(variance);
    if (sd > STDDEV_SAT) sd = STDDEV_SAT;
    res.count = win_count[15:0];
    res.mean  = 24'((mean_acc + (longint'(1) << (MEAN_EXTRA - 1))) >>> MEAN_EXTRA);
    res.sd    = sd[22:0];
    res.lo    = win_lo;
    res.hi    = win_hi;
    res.span  = 25'(int'(win_hi) - int'(win_lo));
    expected_stats.push_back(res);
    clear_window_state();
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  task automatic check_window_result();
    window_stats_t want;
    if (expected_stats.size() == 0) begin
      report_mismatch("result beat with no closed window pending");
      return;
    end
    want = expected_stats.pop_front();
    results_checked++;
    if (sample_count_o !== want.count)
      report_mismatch($sformatf("sample_count %0d, expected %0d", sample_count_o, want.count));
    if (mean_rpm_o !== want.mean)
      report_mismatch($sformatf("mean_rpm %0d, expected %0d", mean_rpm_o, want.mean));
    if (stddev_rpm_o !== want.sd)
      report_mismatch($sformatf("stddev_rpm %0d, expected %0d", stddev_rpm_o, want.sd));
    if (min_rpm_o !== want.lo)
      report_mismatch($sformatf("min_rpm %0d, expected %0d", min_rpm_o, want.lo));
    if (max_rpm_o !== want.hi)
      report_mismatch($sformatf("max_rpm %0d, expected %0d", max_rpm_o, want.hi));
    if (span_rpm_o !== want.span)
      report_mismatch($sformatf("span_rpm %0d, expected %0d", span_rpm_o, want.span));
  endtask

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int draw_gap(inout int quiet_left);
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      quiet_left = $urandom_range(20, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic signed [welf_pkg::SAMPLE_W-1:0] draw_speed(int center);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 24'(center + int'($urandom_range(0, 4096)) - 2048);
    if (r < 80) return 24'($urandom());
    if (r < 90) begin
      case ($urandom_range(0, 4))
        0:       return welf_pkg::SAMPLE_MAX;
        1:       return welf_pkg::SAMPLE_MIN;
        2:       return 24'sd0;
        3:       return -24'sd1;
        default: return 24'sd1;
      endcase
    end
    return 24'(int'($urandom_range(0, 200000)) - 100000);
  endfunction

  always @(posedge clk_i) begin
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    if (in_fire) begin
      beats_accepted++;
      if (mode_i == BEAT_ABORT) aborts_accepted++;
      predict_beat(beat_kind_e'(mode_i), sample_rpm_i);
    end
    if (out_fire) check_window_result();
  end

  always @(negedge clk_i) begin : drive_in
    speed_beat_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_fire) begin
      // The beat stays on the bus until the block takes it.
    end else if (tx_gap > 0) begin
      tx_gap--;
      in_valid_i <= 1'b0;
    end else if (pending_beats.size() != 0) begin
      nxt = pending_beats.pop_front();
      mode_i       <= nxt.kind;
      sample_rpm_i <= nxt.speed;
      in_valid_i   <= 1'b1;
      tx_gap = draw_gap(tx_quiet);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        rx_stall = LONG_HOLD;
      end else if (rx_stall == 0 && (out_fire || $urandom_range(0, 15) == 0)) begin
        rx_stall = draw_gap(rx_quiet);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic push_beat(beat_kind_e kind, logic signed [welf_pkg::SAMPLE_W-1:0] speed);
    speed_beat_t b;
    b.kind  = kind;
    b.speed = speed;
    pending_beats.push_back(b);
  endtask

  // Returns at a falling edge once every beat is taken, every window result
  // has arrived and the last sample has had time to finish inside the block.
  task automatic drain_pipeline();
    do @(posedge clk_i); while (pending_beats.size() != 0 || in_valid_i);
    do @(negedge clk_i); while (expected_stats.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_window(logic [welf_pkg::WINDOW_W-1:0] len);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    window_len = len;
    window_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int phase, win_sel, n_beats, center, random_sent;
    logic [welf_pkg::WINDOW_W-1:0] len;
    clear_window_state();

    // Reset length still in force: four samples must not close a window.
    push_beat(BEAT_ADD, welf_pkg::SAMPLE_MAX);
    push_beat(BEAT_ADD, welf_pkg::SAMPLE_MIN);
    push_beat(BEAT_ADD, 24'sd0);
    push_beat(BEAT_ADD, -24'sd1);
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    drain_pipeline();
    // Lowering the window below the count ends it on the next sample.
    write_window(16'd2);
    push_beat(BEAT_ADD, 24'sh000100);
    drain_pipeline();
    // A zero window acts as a window of one sample.
    write_window(16'd0);
    push_beat(BEAT_ADD, welf_pkg::SAMPLE_MIN);
    push_beat(BEAT_ADD, welf_pkg::SAMPLE_MAX);
    push_beat(BEAT_ADD, 24'sd1);
    drain_pipeline();
    // Full-scale swings exercise the largest deviation and span.
    write_window(16'd2);
    push_beat(BEAT_ADD, welf_pkg::SAMPLE_MIN);
    push_beat(BEAT_ADD, welf_pkg::SAMPLE_MAX);
    push_beat(BEAT_ADD, welf_pkg::SAMPLE_MAX);
    push_beat(BEAT_ADD, welf_pkg::SAMPLE_MIN);
    drain_pipeline();
    write_window(16'hFFFF);
    push_beat(BEAT_ADD, 24'sh0C3500);
    push_beat(BEAT_ADD, 24'sh0C3580);
    push_beat(BEAT_ADD, -24'sh0C3500);
    push_beat(BEAT_ABORT, welf_pkg::SAMPLE_MAX);
    drain_pipeline();
    write_window(16'd3);
    push_beat(BEAT_ADD, 24'sh123456);
    push_beat(BEAT_ABORT, 24'sd0);
    push_beat(BEAT_ADD, 24'sh001000);
    push_beat(BEAT_ADD, 24'sh001080);
    push_beat(BEAT_ADD, 24'sh000F40);

    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_BEATS) begin
      phase++;
      win_sel = $urandom_range(0, 99);
      if (win_sel < 45)      len = $urandom_range(1, 6);
      else if (win_sel < 75) len = $urandom_range(7, 24);
      else if (win_sel < 85) len = 16'd0;
      else if (win_sel < 97) len = $urandom_range(25, 64);
      else                   len = 16'd150;
      n_beats = (len > 64) ? len + 10 : $urandom_range(8, 40);
      if (phase == HOLD_PHASE) begin
        len = 16'd1;
        n_beats = 30;
      end
      center = int'($urandom_range(0, 8000000)) - 4000000;
      drain_pipeline();
      write_window(len);
      // A long receiver stall holds a result and, at the next window end, the input as well.
      if (phase == HOLD_PHASE) hold_armed = 1'b1;
      for (int k = 0; k < n_beats; k++) begin
        if ($urandom_range(0, 99) < 4) push_beat(BEAT_ABORT, draw_speed(center));
        else push_beat(BEAT_ADD, draw_speed(center));
      end
      random_sent += n_beats;
    end
    drain_pipeline();

    $display("Covered %0d accepted beats (%0d aborts) over %0d window length writes,",
             beats_accepted, aborts_accepted, window_writes);
    $display("with %0d window results compared field by field.", results_checked);
    if (mismatches == 0) begin
      $display("running_mean_stddev_min_max_top verification clean");
    end else begin
      $display("running_mean_stddev_min_max_top verification failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("Timeout with %0d results still outstanding.", expected_stats.size());
    $display("running_mean_stddev_min_max_top verification failed");
    $finish;
  end

endmodule

>>> running_mean_stddev_min_max_top.f
hdl/welf_pkg.sv
hdl/welf_divsqrt.sv
hdl/welf_mul.sv
hdl/running_mean_stddev_min_max_top.sv
hdl/welf_checker.sv
dv/running_mean_stddev_min_max_top_tb.sv
